// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hlxfr_pkg.sv =====
// Shared types and constants for the frame receiver.
// Depends on nothing.
package hlxfr_pkg;

    // Header and separator characters
    localparam logic [7:0] CHAR_U     = 8'h55;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // XOR of the fixed header bytes and the colon
    localparam logic [7:0] HDR_XOR = CHAR_U ^ CHAR_N ^ CHAR_E ^ CHAR_R ^ CHAR_COLON;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_OK   = 2'd2,
        KIND_BAD  = 2'd3
    } kind_t;

    // Buffered input transaction handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rx_slot_t;

endpackage

// ===== hw/rtl/hlxfr_in_stage.sv =====
// Input register for received bytes.
// Depends on hlxfr_pkg.
module hlxfr_in_stage
    import hlxfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output rx_slot_t   slot,
    input  logic       take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Accept when empty or when the held byte leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg && !take;
        data_next  = data_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            data_next  = s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign slot.valid = valid_reg;
    assign slot.data  = data_reg;

endmodule

// ===== hw/rtl/hlxfr_parser.sv =====
// Frame parser state machine with the result register.
// Depends on hlxfr_pkg.
module hlxfr_parser
    import hlxfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  rx_slot_t   slot,
    output logic       take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind
);

    typedef enum logic [2:0] {
        PH_U       = 3'd0,
        PH_N       = 3'd1,
        PH_E       = 3'd2,
        PH_R       = 3'd3,
        PH_LEN     = 3'd4,
        PH_COLON   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] xor_reg, xor_next;
    logic       have_cmd_reg, have_cmd_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    kind_t      m_kind_reg, m_kind_next;
    logic [7:0] b;

    // Consume a byte whenever the result register is free or draining
    assign take = slot.valid && (!m_valid_reg || m_ready);
    assign b    = slot.data;

    // Next-state and result logic for one byte
    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        have_cmd_next  = have_cmd_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_kind_next    = m_kind_reg;
        if (take) begin
            unique case (phase_reg)
                PH_N: begin
                    phase_next = (b == CHAR_N) ? PH_E : PH_U;
                end
                PH_E: begin
                    phase_next = (b == CHAR_E) ? PH_R : PH_U;
                end
                PH_R: begin
                    phase_next = (b == CHAR_R) ? PH_LEN : PH_U;
                end
                PH_LEN: begin
                    remaining_next = b;
                    xor_next       = HDR_XOR ^ b;
                    have_cmd_next  = 1'b0;
                    phase_next     = PH_COLON;
                end
                PH_COLON: begin
                    phase_next = (b == CHAR_COLON) ? PH_PAYLOAD : PH_U;
                end
                PH_PAYLOAD: begin
                    m_valid_next = 1'b1;
                    if (remaining_reg > 8'd1) begin
                        // command or data byte streams straight out
                        m_byte_next    = b;
                        m_kind_next    = have_cmd_reg ? KIND_DATA : KIND_CMD;
                        have_cmd_next  = 1'b1;
                        xor_next       = xor_reg ^ b;
                        remaining_next = remaining_reg - 8'd1;
                    end else begin
                        // checksum byte: verdict needs a command byte too
                        m_byte_next = 8'd0;
                        m_kind_next = (xor_reg == b && have_cmd_reg) ? KIND_OK : KIND_BAD;
                        phase_next  = PH_U;
                    end
                end
                default: begin
                    // hunting for the first header byte; unused code lands here too
                    phase_next = (b == CHAR_U) ? PH_N : PH_U;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_U;
            remaining_reg <= 8'd0;
            xor_reg       <= 8'd0;
            have_cmd_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            have_cmd_reg  <= have_cmd_next;
            m_valid_reg   <= m_valid_next;
        end
        m_byte_reg <= m_byte_next;
        m_kind_reg <= m_kind_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_kind     = m_kind_reg;

endmodule

// ===== hw/rtl/header_length_xor_frame_receiver_core.sv =====
// Frame receiver: input register, then parser and result register.
// Path: the byte is registered in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side is free; a stalled result holds the input.
// A byte that yields no result still passes through the input register.
// Reset (aresetn low, synchronous) empties both registers and restarts the header hunt.
module header_length_xor_frame_receiver_core
    import hlxfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind
);

    rx_slot_t slot;
    logic     take;

    // Input register
    hlxfr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .slot      (slot),
        .take      (take)
    );

    // Parser and result register
    hlxfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .slot       (slot),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind)
    );

endmodule

// ===== hw/rtl/hlxfr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
// Depends on hlxfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hlxfr_checker
    import hlxfr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_kind
);

    logic is_verdict;

    // Result carries a verdict rather than a payload byte
    assign is_verdict = m_valid && (m_kind == KIND_OK || m_kind == KIND_BAD);

    // A stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Verdicts carry a zero byte
    `ASSERT_IMPLIES(a_verdict_zero, aclk, aresetn, is_verdict, m_out_byte == 8'd0)

    // A free result side never back-pressures the input
    `ASSERT_IMPLIES(a_ready_flow, aclk, aresetn, m_ready, s_ready)

    // A new result comes from an accepted byte that passed through the input register into the parser
    `ASSERT_IMPLIES(a_result_source, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind header_length_xor_frame_receiver_core hlxfr_checker u_chk (.*);

// ===== tb/header_length_xor_frame_receiver_core_test.sv =====
// Testbench for header_length_xor_frame_receiver_core: drives byte streams of good, corrupt
// and broken frames and checks every result against a built-in deframer predictor.
// Depends on hlxfr_pkg and the core RTL.
module header_length_xor_frame_receiver_core_test;
    import hlxfr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;

    typedef enum logic [2:0] {
        HUNT_U, HUNT_N, HUNT_E, HUNT_R, GET_LEN, GET_COLON, GET_PAYLOAD
    } rx_phase_t;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADER_CHARS} fill_t;

    typedef struct {
        logic [7:0] out_byte;
        kind_t      kind;
    } deframe_result_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic [1:0] m_kind;

    // Predictor state, updated at each accepted input transaction
    rx_phase_t  rx_phase  = HUNT_U;
    logic [7:0] bytes_left = 8'h00;
    logic [7:0] chk_acc    = 8'h00;
    bit         cmd_seen   = 1'b0;
    deframe_result_t pending_results[$];

    bit          sender_gaps_on   = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    int unsigned ready_hold_left  = 0;
    int unsigned bytes_sent       = 0;
    int unsigned frames_accepted  = 0;
    int unsigned frames_rejected  = 0;
    int unsigned payload_bytes    = 0;
    int unsigned error_count      = 0;

    header_length_xor_frame_receiver_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Deframer predictor: one received byte in, zero or one expected result queued
    function void predict_rx(input logic [7:0] b);
        deframe_result_t r;
        case (rx_phase)
            HUNT_N: rx_phase = (b == CHAR_N) ? HUNT_E : HUNT_U;
            HUNT_E: rx_phase = (b == CHAR_E) ? HUNT_R : HUNT_U;
            HUNT_R: rx_phase = (b == CHAR_R) ? GET_LEN : HUNT_U;
            GET_LEN: begin
                bytes_left = b;
                chk_acc    = HDR_XOR ^ b;
                cmd_seen   = 1'b0;
                rx_phase   = GET_COLON;
            end
            GET_COLON: rx_phase = (b == CHAR_COLON) ? GET_PAYLOAD : HUNT_U;
            GET_PAYLOAD: begin
                if (bytes_left > 8'd1) begin
                    r.out_byte = b;
                    r.kind     = cmd_seen ? KIND_DATA : KIND_CMD;
                    cmd_seen   = 1'b1;
                    chk_acc    = chk_acc ^ b;
                    bytes_left = bytes_left - 8'd1;
                end else begin
                    // checksum byte: verdict needs a match and a command byte
                    r.out_byte = 8'h00;
                    r.kind     = (chk_acc == b && cmd_seen) ? KIND_OK : KIND_BAD;
                    rx_phase   = HUNT_U;
                end
                pending_results.push_back(r);
            end
            default: rx_phase = (b == CHAR_U) ? HUNT_N : HUNT_U;
        endcase
    endfunction

    // Random byte, biased toward the header characters
    function logic [7:0] rand_byte();
        case ($urandom_range(0, 19))
            0: return CHAR_U;
            1: return CHAR_N;
            2: return CHAR_E;
            3: return CHAR_R;
            4: return CHAR_COLON;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_HEADER_CHARS: begin
                case ($urandom_range(0, 4))
                    0: return CHAR_U;
                    1: return CHAR_N;
                    2: return CHAR_E;
                    3: return CHAR_R;
                    default: return CHAR_COLON;
                endcase
            end
            default: return rand_byte();
        endcase
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // Send one byte; an optional idle burst comes first
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_rx(b);
        bytes_sent++;
    endtask

    // First count bytes of 'U' 'N' 'E' 'R' len ':'
    task automatic send_header(input logic [7:0] len, input int count);
        logic [7:0] hdr [6];
        int i;
        hdr = '{CHAR_U, CHAR_N, CHAR_E, CHAR_R, len, CHAR_COLON};
        for (i = 0; i < count; i++) send_byte(hdr[i]);
    endtask

    // Complete frame; the parser is brought back to the header hunt first
    task automatic send_frame(input logic [7:0] len, input fill_t fill, input bit corrupt);
        logic [7:0] chk;
        logic [7:0] b;
        int i;
        while (rx_phase != HUNT_U) send_byte(rand_byte());
        send_header(len, 6);
        chk = HDR_XOR ^ len;
        for (i = 1; i < len; i++) begin
            b   = fill_byte(fill);
            chk = chk ^ b;
            send_byte(b);
        end
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Sender goes quiet until every expected result has come back
    task wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task test_directed_cases();
        send_frame(8'd2, FILL_ONES, 1'b0);          // command byte only, good checksum
        send_frame(8'd3, FILL_HEADER_CHARS, 1'b1);  // header chars in payload, bad checksum
        send_frame(8'd0, FILL_RANDOM, 1'b0);        // length zero: no command byte
        send_frame(8'd1, FILL_RANDOM, 1'b0);        // length one: checksum right after colon
        // 'U' in place of the colon sends the parser back to the hunt but does not start a new header
        send_header(8'd5, 5);
        send_byte(CHAR_U);
    endtask

    // Mostly well-formed frames, some broken headers and noise
    task automatic test_random_traffic(input int unsigned until_count);
        int unsigned pick;
        logic [7:0]  len;
        fill_t       fill;
        while (bytes_sent < until_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 99)) inside
                    [0:5]:   len = 8'($urandom_range(0, 1));
                    [6:6]:   len = 8'd255;
                    default: len = 8'($urandom_range(2, 16));
                endcase
                case ($urandom_range(0, 9))
                    0: fill = FILL_ZERO;
                    1: fill = FILL_ONES;
                    2: fill = FILL_HEADER_CHARS;
                    default: fill = FILL_RANDOM;
                endcase
                send_frame(len, fill, $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                // header prefix cut off by a random byte
                send_header(8'($urandom_range(0, 255)), $urandom_range(1, 5));
                send_byte(rand_byte());
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(rand_byte());
            end
        end
    endtask

    task test_longest_frame();
        send_frame(8'd255, FILL_RANDOM, $urandom_range(0, 1) == 1);
    endtask

    // Receiver stalls for a long stretch while a long frame keeps coming
    task test_output_backpressure();
        ready_hold_left = LONG_HOLD;
        send_frame(8'd60, FILL_RANDOM, 1'b0);
        wait_for_results();
    endtask

    task test_full_rate_traffic();
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        test_random_traffic(2000);
    endtask

    // Receiver ready: random stall bursts plus the long hold
    initial begin
        forever begin
            @(posedge aclk);
            if (ready_hold_left > 0) begin
                m_ready <= 1'b0;
                ready_hold_left--;
            end else if (receiver_gaps_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                ready_hold_left = $urandom_range(0, 14);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: each output transaction against the oldest expectation
    always @(posedge aclk) begin
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, kind", {6'd0, m_kind}, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (m_out_byte !== want.out_byte)
                    report_mismatch("out_byte", m_out_byte, want.out_byte);
                if (m_kind !== want.kind)
                    report_mismatch("kind", {6'd0, m_kind}, {6'd0, want.kind});
                case (want.kind)
                    KIND_OK:  frames_accepted++;
                    KIND_BAD: frames_rejected++;
                    default:  payload_bytes++;
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(1500);
        test_longest_frame();
        test_output_backpressure();
        test_full_rate_traffic();
        wait_for_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes: %0d frames accepted, %0d rejected, %0d payload bytes passed on",
                 bytes_sent, frames_accepted, frames_rejected, payload_bytes);
        $display("Covered broken headers, noise, corrupt checksums, lengths 0 to 255, long stall");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
